### src/cidp_pkg.sv
// Package for the client identifier pool allocator.
// Holds sizes, derived widths, request kind codes and result status codes.
// No dependencies.
package cidp_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int CLIENT_COUNT = 64;

    localparam int ID_W     = 64;
    localparam int KIND_W   = 3;
    localparam int CLIENT_W = 6;
    localparam int STATUS_W = 3;

    // slot index into the identifier table
    localparam int SLOT_W    = $clog2(TABLE_DEPTH);
    // counters reach TABLE_DEPTH itself
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int CLIENT_AW = $clog2(CLIENT_COUNT);
    // slot memory: free stack below TABLE_DEPTH, client slots above
    localparam int SMEM_DEPTH = TABLE_DEPTH + CLIENT_COUNT;
    localparam int SMEM_AW    = $clog2(SMEM_DEPTH);

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [ID_W-1:0]     id_t;

    localparam kind_t KIND_CLEAR   = 3'd0;
    localparam kind_t KIND_LOAD    = 3'd1;
    localparam kind_t KIND_ASSIGN  = 3'd2;
    localparam kind_t KIND_RELEASE = 3'd3;
    localparam kind_t KIND_QUERY   = 3'd4;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_HELD      = 3'd1;
    localparam status_t ST_NONE_FREE = 3'd2;
    localparam status_t ST_NOT_HELD  = 3'd3;
    localparam status_t ST_FULL      = 3'd4;
    localparam status_t ST_CLEARED   = 3'd5;

endpackage

### src/client_id_pool_allocator.sv
// Client identifier pool allocator: top level, the only module.
// Depends on cidp_pkg (sizes, codes, types).
//
// Channel   Dir  Handshake            Payload
// request   in   in_valid / in_ready  kind, client, id_value
// result    out  out_valid/out_ready  id_out, status
//
// Sequencing: one request at a time. A request that reads the identifier table
// (an assign, release or query that finds a slot) goes through slot-memory
// lookup, table read and result hand-off; others skip the table read. Slot
// memory and identifier table each have a registered read.
// Reset: asynchronous, active low; counters and hold bits clear at once, no
// clearing pass. A clear request resets them too, with no clearing pass.
// Stalls: a held result in the output register does not block acceptance; a
// new result waits in the hand-off state until the output register drains.
module client_id_pool_allocator
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cidp_pkg::KIND_W-1:0]   kind,
    input  logic [cidp_pkg::CLIENT_W-1:0] client,
    input  logic [cidp_pkg::ID_W-1:0]     id_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cidp_pkg::ID_W-1:0]     id_out,
    output logic [cidp_pkg::STATUS_W-1:0] status
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a request
    localparam logic [1:0] S_LOOK = 2'd1;  // slot memory data valid, decide
    localparam logic [1:0] S_TBL  = 2'd2;  // table data valid
    localparam logic [1:0] S_OUT  = 2'd3;  // hand result to output register

    logic [1:0] state_reg, state_next;

    // captured request (payload, no reset)
    cidp_pkg::kind_t               kind_reg;
    logic [cidp_pkg::CLIENT_W-1:0] client_reg;
    cidp_pkg::id_t                 value_reg;

    // pool bookkeeping
    cidp_pkg::cnt_t loaded_count_reg, loaded_count_next;
    cidp_pkg::cnt_t next_fresh_reg, next_fresh_next;
    cidp_pkg::cnt_t released_top_reg, released_top_next;
    logic [cidp_pkg::CLIENT_COUNT-1:0] holds_reg, holds_next;

    // pending result between decision and output
    cidp_pkg::id_t     res_id_reg, res_id_next;
    cidp_pkg::status_t res_status_reg, res_status_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    cidp_pkg::id_t     id_out_reg, id_out_next;
    cidp_pkg::status_t status_reg, status_next;

    // slot memory: free stack entries and per-client slots, 2 read ports
    logic [cidp_pkg::SLOT_W-1:0] smem [cidp_pkg::SMEM_DEPTH];
    logic                         smem_we;
    logic [cidp_pkg::SMEM_AW-1:0] smem_waddr;
    cidp_pkg::slot_t              smem_wdata;
    logic [cidp_pkg::SMEM_AW-1:0] smem_raddr_a;
    logic [cidp_pkg::SMEM_AW-1:0] smem_raddr_b;
    cidp_pkg::slot_t              smem_rda_reg;
    cidp_pkg::slot_t              smem_rdb_reg;

    // identifier table memory
    cidp_pkg::id_t               tmem [cidp_pkg::TABLE_DEPTH];
    logic                        tmem_we;
    cidp_pkg::slot_t             tmem_waddr;
    cidp_pkg::slot_t             tmem_raddr;
    cidp_pkg::id_t               tmem_rd_reg;

    logic                         accept;
    logic                         in_range;
    logic                         hold_bit;
    logic [cidp_pkg::CLIENT_AW-1:0] cidx;
    cidp_pkg::cnt_t               top_minus1;
    logic                         out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign id_out    = id_out_reg;
    assign status    = status_reg;

    assign cidx       = client_reg[cidp_pkg::CLIENT_AW-1:0];
    assign in_range   = (32'(client_reg) < cidp_pkg::CLIENT_COUNT);
    assign hold_bit   = holds_reg[cidx];
    assign top_minus1 = released_top_reg - cidp_pkg::cnt_t'(1);

    // Reads issued every cycle; data used in S_LOOK belongs to the accept
    // cycle. All writes happen in S_LOOK; no read whose data is used meets a write.
    assign smem_raddr_a = cidp_pkg::SMEM_AW'(cidp_pkg::TABLE_DEPTH)
                          + cidp_pkg::SMEM_AW'(client[cidp_pkg::CLIENT_AW-1:0]);
    assign smem_raddr_b = cidp_pkg::SMEM_AW'(top_minus1[cidp_pkg::SLOT_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (smem_we)
        begin
            smem[smem_waddr] <= smem_wdata;
        end
        smem_rda_reg <= smem[smem_raddr_a];
        smem_rdb_reg <= smem[smem_raddr_b];
    end

    always_ff @(posedge clk)
    begin
        if (tmem_we)
        begin
            tmem[tmem_waddr] <= value_reg;
        end
        tmem_rd_reg <= tmem[tmem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= kind;
            client_reg <= client;
            value_reg  <= id_value;
        end
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
        id_out_reg     <= id_out_next;
        status_reg     <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            loaded_count_reg <= '0;
            next_fresh_reg   <= '0;
            released_top_reg <= '0;
            holds_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            loaded_count_reg <= loaded_count_next;
            next_fresh_reg   <= next_fresh_next;
            released_top_reg <= released_top_next;
            holds_reg        <= holds_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        loaded_count_next = loaded_count_reg;
        next_fresh_next   = next_fresh_reg;
        released_top_next = released_top_reg;
        holds_next        = holds_reg;
        res_id_next       = res_id_reg;
        res_status_next   = res_status_reg;
        out_valid_next    = out_valid_reg;
        id_out_next       = id_out_reg;
        status_next       = status_reg;
        smem_we           = 1'b0;
        smem_waddr        = '0;
        smem_wdata        = '0;
        tmem_we           = 1'b0;
        tmem_waddr        = loaded_count_reg[cidp_pkg::SLOT_W-1:0];
        tmem_raddr        = smem_rda_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                res_id_next     = '0;
                res_status_next = cidp_pkg::ST_OK;
                state_next      = S_OUT;
                case (kind_reg)
                    cidp_pkg::KIND_CLEAR:
                    begin
                        loaded_count_next = '0;
                        next_fresh_next   = '0;
                        released_top_next = '0;
                        holds_next        = '0;
                        res_status_next   = cidp_pkg::ST_CLEARED;
                    end
                    cidp_pkg::KIND_LOAD:
                    begin
                        if (loaded_count_reg < cidp_pkg::cnt_t'(cidp_pkg::TABLE_DEPTH))
                        begin
                            tmem_we           = 1'b1;
                            loaded_count_next = loaded_count_reg + cidp_pkg::cnt_t'(1);
                            res_id_next       = value_reg;
                        end
                        else
                        begin
                            res_status_next = cidp_pkg::ST_FULL;
                        end
                    end
                    cidp_pkg::KIND_ASSIGN:
                    begin
                        smem_waddr = cidp_pkg::SMEM_AW'(cidp_pkg::TABLE_DEPTH)
                                     + cidp_pkg::SMEM_AW'(cidx);
                        if (!in_range)
                        begin
                            res_status_next = cidp_pkg::ST_NOT_HELD;
                        end
                        else if (hold_bit)
                        begin
                            res_status_next = cidp_pkg::ST_HELD;
                            state_next      = S_TBL;
                        end
                        else if (released_top_reg != '0)
                        begin
                            // most recently released slot first
                            released_top_next = top_minus1;
                            smem_we           = 1'b1;
                            smem_wdata        = smem_rdb_reg;
                            holds_next[cidx]  = 1'b1;
                            tmem_raddr        = smem_rdb_reg;
                            state_next        = S_TBL;
                        end
                        else if (next_fresh_reg < loaded_count_reg)
                        begin
                            smem_we          = 1'b1;
                            smem_wdata       = next_fresh_reg[cidp_pkg::SLOT_W-1:0];
                            holds_next[cidx] = 1'b1;
                            next_fresh_next  = next_fresh_reg + cidp_pkg::cnt_t'(1);
                            tmem_raddr       = next_fresh_reg[cidp_pkg::SLOT_W-1:0];
                            state_next       = S_TBL;
                        end
                        else
                        begin
                            res_status_next = cidp_pkg::ST_NONE_FREE;
                        end
                    end
                    cidp_pkg::KIND_RELEASE:
                    begin
                        if (!in_range || !hold_bit ||
                            released_top_reg >= cidp_pkg::cnt_t'(cidp_pkg::TABLE_DEPTH))
                        begin
                            res_status_next = cidp_pkg::ST_NOT_HELD;
                        end
                        else
                        begin
                            // push held slot onto the free stack
                            smem_we    = 1'b1;
                            smem_waddr = cidp_pkg::SMEM_AW'(
                                released_top_reg[cidp_pkg::SLOT_W-1:0]);
                            smem_wdata = smem_rda_reg;
                            released_top_next = released_top_reg + cidp_pkg::cnt_t'(1);
                            holds_next[cidx]  = 1'b0;
                            state_next        = S_TBL;
                        end
                    end
                    cidp_pkg::KIND_QUERY:
                    begin
                        if (in_range && hold_bit)
                        begin
                            state_next = S_TBL;
                        end
                        else
                        begin
                            res_status_next = cidp_pkg::ST_NOT_HELD;
                        end
                    end
                    default:
                    begin
                        res_status_next = cidp_pkg::ST_OK;
                    end
                endcase
            end
            S_TBL:
            begin
                res_id_next = tmem_rd_reg;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    id_out_next    = res_id_reg;
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // every slot handed out fresh is either held or back on the free stack
    a_slot_conservation: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(holds_reg) + int'(released_top_reg)) == int'(next_fresh_reg))
        else $error("slot accounting broken");

    a_fresh_within_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        next_fresh_reg <= loaded_count_reg)
        else $error("fresh pointer beyond loaded entries");

    a_accept_starts_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_LOOK) && !in_ready)
        else $error("request accepted without lookup");

    a_status_code_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= cidp_pkg::ST_CLEARED))
        else $error("undefined status code");

endmodule

### tb/tb_client_id_pool_allocator.sv
// Self-checking testbench for client_id_pool_allocator.
// Depends on cidp_pkg and the RTL top. A directed table runs first, then random
// request phases, scored against an in-bench pool model or a row's fixed reply.
module tb_client_id_pool_allocator;

    typedef logic [cidp_pkg::CLIENT_W-1:0] client_idx_t;

    // Kind codes the block ignores
    localparam cidp_pkg::kind_t KIND_SPARE_A = 3'd5;
    localparam cidp_pkg::kind_t KIND_SPARE_B = 3'd6;
    localparam cidp_pkg::kind_t KIND_SPARE_C = 3'd7;

    localparam int ITEM_TARGET  = 450;
    localparam int TAIL_ITEMS   = 50;
    localparam int LIMIT_CYCLES = 200000;

    typedef struct packed {
        cidp_pkg::kind_t   kind;
        client_idx_t       client;
        cidp_pkg::id_t     value;
        bit                fixed;
        cidp_pkg::id_t     fixed_id;
        cidp_pkg::status_t fixed_st;
    } plan_row_t;

    typedef struct packed {
        cidp_pkg::id_t     id;
        cidp_pkg::status_t st;
    } reply_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    cidp_pkg::kind_t   kind;
    client_idx_t       client;
    cidp_pkg::id_t     id_value;
    logic              out_valid;
    logic              out_ready;
    cidp_pkg::id_t     id_out;
    cidp_pkg::status_t status;

    client_id_pool_allocator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .client    (client),
        .id_value  (id_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .id_out    (id_out),
        .status    (status)
    );

    // Pool model state
    cidp_pkg::id_t   pool_ids [cidp_pkg::TABLE_DEPTH];
    cidp_pkg::slot_t free_slots [cidp_pkg::TABLE_DEPTH];
    cidp_pkg::cnt_t  loaded_n   = '0;
    cidp_pkg::cnt_t  fresh_next = '0;
    cidp_pkg::cnt_t  free_top   = '0;
    bit              holds [cidp_pkg::CLIENT_COUNT];
    cidp_pkg::slot_t held_slot [cidp_pkg::CLIENT_COUNT];

    reply_t    awaited_replies [$];
    plan_row_t plan [$];

    int  error_count;
    int  results_checked;
    int  sent_count;
    int  full_seen;
    int  none_free_seen;
    int  cycle_count;
    int  kind_tally [8];
    bit  calm_tail;
    bit  source_gaps;
    bit  sink_stalls;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Updates the pool model with one request and returns the reply it gives.
    function automatic void pool_predict(input cidp_pkg::kind_t k, input client_idx_t c,
                                         input cidp_pkg::id_t v,
                                         output cidp_pkg::id_t id,
                                         output cidp_pkg::status_t st);
        bit in_range;
        int i;
        in_range = (int'(c) < cidp_pkg::CLIENT_COUNT);
        id = '0;
        st = cidp_pkg::ST_OK;
        case (k)
            cidp_pkg::KIND_CLEAR:
            begin
                loaded_n   = '0;
                fresh_next = '0;
                free_top   = '0;
                for (i = 0; i < cidp_pkg::CLIENT_COUNT; i++)
                    holds[i] = 1'b0;
                st = cidp_pkg::ST_CLEARED;
            end
            cidp_pkg::KIND_LOAD:
            begin
                if (loaded_n < cidp_pkg::TABLE_DEPTH)
                begin
                    pool_ids[loaded_n[cidp_pkg::SLOT_W-1:0]] = v;
                    loaded_n = loaded_n + 1'b1;
                    id = v;
                end
                else
                    st = cidp_pkg::ST_FULL;
            end
            cidp_pkg::KIND_ASSIGN:
            begin
                if (!in_range)
                    st = cidp_pkg::ST_NOT_HELD;
                else if (holds[c])
                begin
                    id = pool_ids[held_slot[c]];
                    st = cidp_pkg::ST_HELD;
                end
                else if (free_top > 0)
                begin
                    // most recently released slot goes out first
                    free_top = free_top - 1'b1;
                    held_slot[c] = free_slots[free_top[cidp_pkg::SLOT_W-1:0]];
                    holds[c] = 1'b1;
                    id = pool_ids[held_slot[c]];
                end
                else if (fresh_next < loaded_n)
                begin
                    held_slot[c] = fresh_next[cidp_pkg::SLOT_W-1:0];
                    holds[c] = 1'b1;
                    fresh_next = fresh_next + 1'b1;
                    id = pool_ids[held_slot[c]];
                end
                else
                    st = cidp_pkg::ST_NONE_FREE;
            end
            cidp_pkg::KIND_RELEASE:
            begin
                if (!in_range || !holds[c] || free_top >= cidp_pkg::TABLE_DEPTH)
                    st = cidp_pkg::ST_NOT_HELD;
                else
                begin
                    free_slots[free_top[cidp_pkg::SLOT_W-1:0]] = held_slot[c];
                    free_top = free_top + 1'b1;
                    holds[c] = 1'b0;
                    id = pool_ids[held_slot[c]];
                end
            end
            cidp_pkg::KIND_QUERY:
            begin
                if (in_range && holds[c])
                    id = pool_ids[held_slot[c]];
                else
                    st = cidp_pkg::ST_NOT_HELD;
            end
            default: ;
        endcase
    endfunction

    function automatic cidp_pkg::id_t random_id();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '1;
        if (r == 1)
            return '0;
        return {$urandom, $urandom};
    endfunction

    task automatic add_plan(input cidp_pkg::kind_t k, input client_idx_t c,
                            input cidp_pkg::id_t v, input bit fixed,
                            input cidp_pkg::id_t fid, input cidp_pkg::status_t fst);
        plan_row_t r;
        r.kind     = k;
        r.client   = c;
        r.value    = v;
        r.fixed    = fixed;
        r.fixed_id = fid;
        r.fixed_st = fst;
        plan.insert(plan.size(), r);
    endtask

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_request(input cidp_pkg::kind_t k, input client_idx_t c,
                                input cidp_pkg::id_t v, input bit fixed,
                                input cidp_pkg::id_t fid, input cidp_pkg::status_t fst);
        reply_t            want;
        cidp_pkg::id_t     pid;
        cidp_pkg::status_t pst;
        if (source_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        client   <= c;
        id_value <= v;
        do
            @(posedge clk);
        while (!in_ready);

        pool_predict(k, c, v, pid, pst);
        want.id = fixed ? fid : pid;
        want.st = fixed ? fst : pst;
        awaited_replies.insert(awaited_replies.size(), want);

        kind_tally[k]++;
        if (want.st == cidp_pkg::ST_FULL)
            full_seen++;
        if (want.st == cidp_pkg::ST_NONE_FREE)
            none_free_seen++;
        sent_count++;
        if (sent_count >= ITEM_TARGET - TAIL_ITEMS)
        begin
            calm_tail   = 1'b1;
            source_gaps = 1'b0;
            sink_stalls = 1'b0;
        end
    endtask

    // Hold off new requests until every outstanding reply is back.
    task automatic drain_pause();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_replies.size() != 0);
    endtask

    // Result side: ready with random stall bursts
    initial
    begin : sink
        int hold;
        hold = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else if (sink_stalls && $urandom_range(0, 4) == 0)
            begin
                hold = $urandom_range(1, 14) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : scoreboard
        reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_replies.size() == 0)
            begin
                $display("%0t: unexpected result id_out %h status %0d",
                         $time, id_out, status);
                error_count++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                results_checked++;
                if (id_out !== want.id)
                begin
                    $display("%0t: id_out mismatch, expected %h, got %h",
                             $time, want.id, id_out);
                    error_count++;
                end
                if (status !== want.st)
                begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.st, status);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_client_id_pool_allocator: errors");
        $finish;
    end

    initial
    begin : stimulus
        int              n_loads;
        int              n_ops;
        int              pick;
        int              phase;
        int              i;
        int              j;
        cidp_pkg::kind_t kd;
        client_idx_t     c;
        plan_row_t       row;

        in_valid    <= 1'b0;
        kind        <= cidp_pkg::KIND_CLEAR;
        client      <= '0;
        id_value    <= '0;
        rst_n       <= 1'b0;
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        calm_tail   = 1'b0;

        // Directed: empty pool, loads at the value extremes, reuse order of
        // released slots, already-held, exhaustion, spare codes, clear.
        add_plan(cidp_pkg::KIND_QUERY,   6'd0,  '0, 1'b1, '0, cidp_pkg::ST_NOT_HELD);
        add_plan(cidp_pkg::KIND_ASSIGN,  6'd5,  '0, 1'b1, '0, cidp_pkg::ST_NONE_FREE);
        add_plan(cidp_pkg::KIND_RELEASE, 6'd5,  '1, 1'b1, '0, cidp_pkg::ST_NOT_HELD);
        add_plan(cidp_pkg::KIND_LOAD,    6'd63, '1, 1'b1, '1, cidp_pkg::ST_OK);
        add_plan(cidp_pkg::KIND_LOAD,    6'd0,  '0, 1'b1, '0, cidp_pkg::ST_OK);
        add_plan(cidp_pkg::KIND_LOAD,    6'd9,  64'h0123_4567_89ab_cdef, 1'b1,
                 64'h0123_4567_89ab_cdef, cidp_pkg::ST_OK);
        add_plan(cidp_pkg::KIND_ASSIGN,  6'd63, '0, 1'b0, '0, cidp_pkg::ST_OK);
        add_plan(cidp_pkg::KIND_ASSIGN,  6'd63, '0, 1'b0, '0, cidp_pkg::ST_OK);
        add_plan(cidp_pkg::KIND_ASSIGN,  6'd0,  '1, 1'b0, '0, cidp_pkg::ST_OK);
        add_plan(cidp_pkg::KIND_QUERY,   6'd63, '0, 1'b0, '0, cidp_pkg::ST_OK);
        add_plan(cidp_pkg::KIND_RELEASE, 6'd63, '0, 1'b0, '0, cidp_pkg::ST_OK);
        add_plan(cidp_pkg::KIND_ASSIGN,  6'd42, '0, 1'b0, '0, cidp_pkg::ST_OK);
        add_plan(cidp_pkg::KIND_RELEASE, 6'd0,  '0, 1'b0, '0, cidp_pkg::ST_OK);
        add_plan(cidp_pkg::KIND_RELEASE, 6'd42, '0, 1'b0, '0, cidp_pkg::ST_OK);
        add_plan(cidp_pkg::KIND_ASSIGN,  6'd21, '0, 1'b0, '0, cidp_pkg::ST_OK);
        add_plan(cidp_pkg::KIND_ASSIGN,  6'd1,  '0, 1'b0, '0, cidp_pkg::ST_OK);
        add_plan(cidp_pkg::KIND_ASSIGN,  6'd2,  '0, 1'b0, '0, cidp_pkg::ST_OK);
        add_plan(cidp_pkg::KIND_ASSIGN,  6'd3,  '0, 1'b0, '0, cidp_pkg::ST_OK);
        add_plan(KIND_SPARE_A,           6'd63, '1, 1'b1, '0, cidp_pkg::ST_OK);
        add_plan(KIND_SPARE_B,           6'd21, '1, 1'b1, '0, cidp_pkg::ST_OK);
        add_plan(KIND_SPARE_C,           6'd0,  '0, 1'b1, '0, cidp_pkg::ST_OK);
        add_plan(cidp_pkg::KIND_CLEAR,   6'd0,  '0, 1'b1, '0, cidp_pkg::ST_CLEARED);
        add_plan(cidp_pkg::KIND_QUERY,   6'd21, '0, 1'b1, '0, cidp_pkg::ST_NOT_HELD);
        add_plan(cidp_pkg::KIND_ASSIGN,  6'd21, '0, 1'b1, '0, cidp_pkg::ST_NONE_FREE);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < plan.size(); i++)
        begin
            row = plan[i];
            send_request(row.kind, row.client, row.value, row.fixed,
                         row.fixed_id, row.fixed_st);
        end

        // Random phases: clear, a batch of loads, then mixed traffic on a few
        // hot clients. The second phase overfills the table.
        phase = 0;
        while (sent_count < ITEM_TARGET)
        begin
            if (!calm_tail)
            begin
                source_gaps = ($urandom_range(0, 2) != 0);
                sink_stalls = ($urandom_range(0, 2) != 0);
            end
            if (phase == 0 || (!calm_tail && $urandom_range(0, 3) == 0))
                drain_pause();
            send_request(cidp_pkg::KIND_CLEAR,
                         client_idx_t'($urandom_range(0, cidp_pkg::CLIENT_COUNT - 1)),
                         random_id(), 1'b0, '0, cidp_pkg::ST_OK);
            n_loads = (phase == 1) ? cidp_pkg::TABLE_DEPTH + 3 : $urandom_range(0, 12);
            repeat (n_loads)
                send_request(cidp_pkg::KIND_LOAD,
                             client_idx_t'($urandom_range(0, cidp_pkg::CLIENT_COUNT - 1)),
                             random_id(), 1'b0, '0, cidp_pkg::ST_OK);
            n_ops = $urandom_range(20, 45);
            for (j = 0; j < n_ops && sent_count < ITEM_TARGET; j++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    kd = cidp_pkg::KIND_ASSIGN;
                else if (pick < 60)
                    kd = cidp_pkg::KIND_RELEASE;
                else if (pick < 78)
                    kd = cidp_pkg::KIND_QUERY;
                else if (pick < 90)
                    kd = cidp_pkg::KIND_LOAD;
                else if (pick < 93)
                    kd = cidp_pkg::KIND_CLEAR;
                else
                    kd = cidp_pkg::kind_t'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
                if ($urandom_range(0, 3) != 0)
                    c = client_idx_t'($urandom_range(0, 5));
                else
                    c = client_idx_t'($urandom_range(0, cidp_pkg::CLIENT_COUNT - 1));
                send_request(kd, c, random_id(), 1'b0, '0, cidp_pkg::ST_OK);
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d clear, %0d load, %0d assign, %0d release, %0d query, %0d spare",
                 kind_tally[cidp_pkg::KIND_CLEAR], kind_tally[cidp_pkg::KIND_LOAD],
                 kind_tally[cidp_pkg::KIND_ASSIGN], kind_tally[cidp_pkg::KIND_RELEASE],
                 kind_tally[cidp_pkg::KIND_QUERY],
                 kind_tally[KIND_SPARE_A] + kind_tally[KIND_SPARE_B]
                 + kind_tally[KIND_SPARE_C]);
        $display("Checked %0d results; table full %0d times, pool empty %0d times",
                 results_checked, full_seen, none_free_seen);
        if (error_count == 0)
            $display("tb_client_id_pool_allocator: clean");
        else
            $display("tb_client_id_pool_allocator: errors");
        $finish;
    end

endmodule
